/* hdl/bit_stream_packer_unpacker_top_assert.svh */
// Assertion macros for the bit stream packer/unpacker.
// Included by the RTL modules that carry concurrent checks; no dependencies.
`ifndef BIT_STREAM_PACKER_UNPACKER_TOP_ASSERT_SVH
`define BIT_STREAM_PACKER_UNPACKER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSPU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bspu_pkg.sv */
// Shared types, constants and helpers of the bit stream packer/unpacker.
// No dependencies.
package bspu_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WIN_BYTES = 5;
  localparam int unsigned WIN_W     = WIN_BYTES * BYTE_W;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_REWIND = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] read_value;
    logic              overflow;
  } result_t;

  // Mask of the low n bits, n in 0..DATA_W.
  function automatic logic [DATA_W-1:0] low_mask(input logic [LEN_W-1:0] n);
    logic [DATA_W-1:0] m;
    if (n >= LEN_W'(DATA_W)) begin
      m = '1;
    end else begin
      m = (DATA_W'(1) << n) - DATA_W'(1);
    end
    return m;
  endfunction

  // Byte j of the window, byte 0 being the most significant.
  function automatic logic [BYTE_W-1:0] win_byte(input logic [WIN_W-1:0] win,
                                                 input logic [2:0] j);
    logic [BYTE_W-1:0] b;
    case (j)
      3'd0:    b = win[39:32];
      3'd1:    b = win[31:24];
      3'd2:    b = win[23:16];
      3'd3:    b = win[15:8];
      3'd4:    b = win[7:0];
      default: b = '0;
    endcase
    return b;
  endfunction

  // Replace byte j of the window.
  function automatic logic [WIN_W-1:0] win_set(input logic [WIN_W-1:0] win,
                                               input logic [2:0] j,
                                               input logic [BYTE_W-1:0] b);
    logic [WIN_W-1:0] w;
    w = win;
    case (j)
      3'd0:    w[39:32] = b;
      3'd1:    w[31:24] = b;
      3'd2:    w[23:16] = b;
      3'd3:    w[15:8]  = b;
      3'd4:    w[7:0]   = b;
      default: w = win;
    endcase
    return w;
  endfunction

endpackage

/* hdl/bspu_if.sv */
// Valid/ready channel interfaces for items and results.
// Depends on bspu_pkg for the field widths.
interface bspu_in_if;
  logic                          valid;
  logic                          ready;
  logic [bspu_pkg::OP_W-1:0]     operation;
  logic [bspu_pkg::DATA_W-1:0]   write_value;
  logic [bspu_pkg::LEN_W-1:0]    field_bits;

  modport source (output valid, output operation, output write_value, output field_bits,
                  input ready);
  modport sink   (input valid, input operation, input write_value, input field_bits,
                  output ready);
endinterface

interface bspu_out_if;
  logic                          valid;
  logic                          ready;
  logic [bspu_pkg::DATA_W-1:0]   read_value;
  logic                          overflow;

  modport source (output valid, output read_value, output overflow, input ready);
  modport sink   (input valid, input read_value, input overflow, output ready);
endinterface

/* hdl/bit_stream_packer_unpacker_top.sv */
// Top level of the MSB-first bit stream packer/unpacker.
// Depends on bspu_pkg, bspu_if, bspu_ram and bspu_seq.
//
//  channel  | dir | payload                                  | transfer when
//  ---------+-----+------------------------------------------+------------------
//  in_i     | in  | operation, write_value, field_bits       | valid && ready
//  out_o    | out | read_value, overflow                     | valid && ready
//
// Sequence: a write or read that is carried out walks B bytes of the store
//   (1..5); the first byte is fetched with the transfer, then each step
//   writes back (or captures) one byte and fetches the next. A new item is
//   taken no earlier than the cycle in which the last result is handed on.
//   Rewind, unused codes, zero widths and overflowing accesses skip the walk.
//   Single store ports: one byte fetched, one written or captured per cycle.
// Reset: the cursor returns to bit 0 and a clearing pass zeroes the store,
//   one byte per cycle, while in_i.ready stays low.
// Stalls: the result waits in an output register; a further item is worked
//   on meanwhile and holds its result until that register frees up.
module bit_stream_packer_unpacker_top #(
  parameter int unsigned BUF_BYTES      = 128,
  parameter int unsigned MAX_FIELD_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bspu_in_if.sink    in_i,
  bspu_out_if.source out_o
);

  localparam int unsigned AW = $clog2(BUF_BYTES);

  bspu_pkg::result_t                 res;
  logic                              slot_free;
  logic                              ram_we;
  logic [AW-1:0]                     ram_waddr;
  logic [7:0]                        ram_wdata;
  logic [AW-1:0]                     ram_raddr;
  logic [7:0]                        ram_rdata;

  logic                              out_valid_q, out_valid_d;
  logic [bspu_pkg::DATA_W-1:0]       out_value_q;
  logic                              out_ovf_q;

  // Byte store: all persistent stream data lives here.
  bspu_ram #(
    .WIDTH (8),
    .DEPTH (BUF_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Cursor, clearing pass and read-modify-write walk.
  bspu_seq #(
    .BUF_BYTES      (BUF_BYTES),
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .slot_free_i (slot_free),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // The output register is free when empty or when its result leaves now.
  assign slot_free = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (res.valid && slot_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load the payload only with a new result; hold it while stalled.
  always_ff @(posedge clk_i) begin
    if (res.valid && slot_free) begin
      out_value_q <= res.read_value;
      out_ovf_q   <= res.overflow;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = out_value_q;
  assign out_o.overflow   = out_ovf_q;

endmodule

/* hdl/bspu_ram.sv */
// Generic single-clock RAM, one write port and one read port, registered read.
// No dependencies.
module bspu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/bspu_seq.sv */
// Cursor and byte sequencer: clears the store, walks the bytes of a field
// with read-modify-write. Depends on bspu_pkg, bspu_if and the assert header.
`include "bit_stream_packer_unpacker_top_assert.svh"

module bspu_seq #(
  parameter int unsigned BUF_BYTES      = 128,
  parameter int unsigned MAX_FIELD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bspu_in_if.sink                      in_i,
  input  logic                         slot_free_i,
  output bspu_pkg::result_t            res_o,
  output logic                         ram_we_o,
  output logic [$clog2(BUF_BYTES)-1:0] ram_waddr_o,
  output logic [7:0]                   ram_wdata_o,
  output logic [$clog2(BUF_BYTES)-1:0] ram_raddr_o,
  input  logic [7:0]                   ram_rdata_i
);

  localparam int unsigned AW    = $clog2(BUF_BYTES);
  localparam int unsigned LIMIT = BUF_BYTES * 8;
  localparam int unsigned PW    = $clog2(LIMIT + 1);
  localparam int unsigned LW    = bspu_pkg::LEN_W;
  localparam int unsigned WW    = bspu_pkg::WIN_W;
  localparam int unsigned DW    = bspu_pkg::DATA_W;

  bspu_pkg::state_e state_q, state_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [AW-1:0]    base_q, base_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [2:0]       k_q, k_d;
  logic [WW-1:0]    win_q, win_d;
  logic [LW-1:0]    sh_q, sh_d;
  logic [LW-1:0]    n_q, n_d;
  logic             is_wr_q, is_wr_d;
  logic             rd_ok_q, rd_ok_d;
  logic             ovf_q, ovf_d;

  bspu_pkg::op_e    op;
  logic             in_ready;
  logic             accept;
  logic [LW-1:0]    n_sat;
  logic [2:0]       off;
  logic [PW:0]      end_sum;
  logic             past_end;
  logic [LW-1:0]    span;
  logic [LW-1:0]    sh_new;
  logic [WW-1:0]    win_wr;
  logic [2:0]       j;
  logic [WW-1:0]    win_rd;

  // Decode of the item on the input channel.
  always_comb begin
    op       = bspu_pkg::op_e'(in_i.operation);
    n_sat    = (in_i.field_bits > LW'(MAX_FIELD_BITS)) ? LW'(MAX_FIELD_BITS)
                                                       : in_i.field_bits;
    off      = pos_q[2:0];
    end_sum  = {1'b0, pos_q} + (PW+1)'(n_sat);
    past_end = end_sum > (PW+1)'(LIMIT);
    span     = LW'(off) + n_sat - LW'(1);
    sh_new   = LW'(WW) - n_sat - LW'(off);
    win_wr   = WW'(in_i.write_value & bspu_pkg::low_mask(n_sat)) << sh_new;
  end

  assign in_ready   = (state_q == bspu_pkg::ST_IDLE) ||
                      ((state_q == bspu_pkg::ST_DONE) && slot_free_i);
  assign accept     = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  assign j      = k_q - 3'd1;
  assign win_rd = win_q >> sh_q;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    clr_d       = clr_q;
    base_d      = base_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    win_d       = win_q;
    sh_d        = sh_q;
    n_d         = n_q;
    is_wr_d     = is_wr_q;
    rd_ok_d     = rd_ok_q;
    ovf_d       = ovf_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = base_q + AW'(j);
    ram_wdata_o = ram_rdata_i | bspu_pkg::win_byte(win_q, j);
    ram_raddr_o = pos_q[AW+2:3];

    case (state_q)
      bspu_pkg::ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = '0;
        if (clr_q == AW'(BUF_BYTES - 1)) begin
          state_d = bspu_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      bspu_pkg::ST_ACCESS: begin
        // Write back (or capture) the byte read last cycle, fetch the next one.
        if (is_wr_q) begin
          ram_we_o = 1'b1;
        end else begin
          win_d = bspu_pkg::win_set(win_q, j, ram_rdata_i);
        end
        ram_raddr_o = base_q + AW'(k_q);
        if (k_q < cnt_q) begin
          k_d = k_q + 3'd1;
        end else begin
          state_d = bspu_pkg::ST_DONE;
        end
      end
      bspu_pkg::ST_DONE: begin
        if (slot_free_i) begin
          state_d = bspu_pkg::ST_IDLE;
        end
      end
      default: begin
      end
    endcase

    // Start of an item; the first byte read goes out with the transfer.
    if (accept) begin
      ovf_d   = 1'b0;
      rd_ok_d = 1'b0;
      state_d = bspu_pkg::ST_DONE;
      if (op == bspu_pkg::OP_REWIND) begin
        pos_d = '0;
      end else if ((op == bspu_pkg::OP_WRITE || op == bspu_pkg::OP_READ) &&
                   (n_sat != '0)) begin
        if (past_end) begin
          ovf_d = 1'b1;
        end else begin
          pos_d   = end_sum[PW-1:0];
          base_d  = pos_q[AW+2:3];
          cnt_d   = 3'(span >> 3) + 3'd1;
          k_d     = 3'd1;
          sh_d    = sh_new;
          n_d     = n_sat;
          is_wr_d = (op == bspu_pkg::OP_WRITE);
          rd_ok_d = (op == bspu_pkg::OP_READ);
          win_d   = (op == bspu_pkg::OP_WRITE) ? win_wr : '0;
          state_d = bspu_pkg::ST_ACCESS;
        end
      end
    end
  end

  always_comb begin
    res_o.valid      = (state_q == bspu_pkg::ST_DONE);
    res_o.overflow   = ovf_q;
    res_o.read_value = rd_ok_q ? (win_rd[DW-1:0] & bspu_pkg::low_mask(n_q)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bspu_pkg::ST_CLEAR;
      pos_q   <= '0;
      clr_q   <= '0;
      k_q     <= '0;
      cnt_q   <= '0;
      is_wr_q <= 1'b0;
      rd_ok_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      clr_q   <= clr_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      is_wr_q <= is_wr_d;
      rd_ok_q <= rd_ok_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    win_q  <= win_d;
    sh_q   <= sh_d;
    n_q    <= n_d;
  end

  `BSPU_ASSERT_NOW(a_no_take_in_clear, clk_i, rst_ni, state_q == bspu_pkg::ST_CLEAR, !in_ready, "item taken during clearing pass")
  `BSPU_ASSERT_NOW(a_we_source, clk_i, rst_ni, ram_we_o, (state_q == bspu_pkg::ST_CLEAR) || (state_q == bspu_pkg::ST_ACCESS && is_wr_q), "store written outside clear or write item")
  `BSPU_ASSERT_NOW(a_cursor_bound, clk_i, rst_ni, 1'b1, pos_q <= PW'(LIMIT), "cursor beyond end of store")
  `BSPU_ASSERT_NOW(a_walk_bound, clk_i, rst_ni, state_q == bspu_pkg::ST_ACCESS, (k_q >= 3'd1) && (k_q <= cnt_q) && (cnt_q <= 3'd5), "byte walk out of range")
  `BSPU_ASSERT_NEXT(a_overflow_no_move, clk_i, rst_ni, accept && past_end && (n_sat != '0) && (op == bspu_pkg::OP_WRITE || op == bspu_pkg::OP_READ), ovf_q && $stable(pos_q), "overflowing access moved the cursor")

endmodule

/* tb/tb_bit_stream_packer_unpacker_top.sv */
// Self-checking testbench for the MSB-first bit stream packer/unpacker.
// Depends on bspu_pkg, bspu_if and the RTL under hdl; drives items through a
// directed table and random access streams, checks results against a shadow.
module tb_bit_stream_packer_unpacker_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Store geometry matches the parameters the block is built with below.
  localparam int unsigned STORE_BYTES    = 128;
  localparam int unsigned WIDEST_FIELD   = 32;
  localparam int unsigned STORE_BITS     = STORE_BYTES * bspu_pkg::BYTE_W;
  localparam int unsigned RANDOM_ITEMS   = 1850;
  localparam int unsigned IDLE_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned N_DIRECTED     = 20;

  typedef struct packed {
    logic [bspu_pkg::DATA_W-1:0] read_value;
    logic                        overflow;
  } outcome_t;

  // One row of the directed table; has_typed marks rows whose outcome is
  // written in by hand rather than taken from the shadow.
  typedef struct packed {
    bspu_pkg::op_e               op;
    logic [bspu_pkg::DATA_W-1:0] value;
    logic [bspu_pkg::LEN_W-1:0]  bits;
    logic                        has_typed;
    logic [bspu_pkg::DATA_W-1:0] typed_value;
    logic                        typed_overflow;
  } vector_t;

  logic clk_i;
  logic rst_ni;

  bspu_in_if  items_ch ();
  bspu_out_if results_ch ();

  bit_stream_packer_unpacker_top #(
    .BUF_BYTES      (STORE_BYTES),
    .MAX_FIELD_BITS (WIDEST_FIELD)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (items_ch),
    .out_o  (results_ch)
  );

  // Shadow of the byte store and the bit cursor, kept in step with every
  // item at the moment it is handed to the block.
  logic [bspu_pkg::BYTE_W-1:0] shadow_store [STORE_BYTES];
  int unsigned                 shadow_cursor;

  // Outcomes owed by the block, oldest first.
  outcome_t outcomes_due [$];

  int unsigned error_count;
  int unsigned items_sent;
  int unsigned items_counted;
  int unsigned results_seen;
  int unsigned reads_done;
  int unsigned writes_done;
  int unsigned refusals_seen;
  int unsigned burst_left;
  bit          sender_steady;

  // Directed table: after-reset read, extremes, every operation, zero and
  // oversized widths, a wide value and a five-byte straddle.
  vector_t directed_table [N_DIRECTED] = '{
    '{bspu_pkg::OP_READ,   32'hDEAD_BEEF, 6'd32, 1'b1, 32'h0000_0000, 1'b0},
    '{bspu_pkg::OP_REWIND, 32'h0000_0000, 6'd0,  1'b1, 32'h0000_0000, 1'b0},
    '{bspu_pkg::OP_WRITE,  32'hFFFF_FFFF, 6'd32, 1'b1, 32'h0000_0000, 1'b0},
    '{bspu_pkg::OP_REWIND, 32'hFFFF_FFFF, 6'd63, 1'b1, 32'h0000_0000, 1'b0},
    '{bspu_pkg::OP_READ,   32'h0000_0000, 6'd32, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{bspu_pkg::OP_WRITE,  32'hFFFF_FFFE, 6'd1,  1'b0, 32'h0,         1'b0},
    '{bspu_pkg::OP_WRITE,  32'h0000_0005, 6'd3,  1'b0, 32'h0,         1'b0},
    '{bspu_pkg::OP_WRITE,  32'hFFFF_FFFF, 6'd0,  1'b1, 32'h0000_0000, 1'b0},
    '{bspu_pkg::OP_READ,   32'h0000_0000, 6'd0,  1'b1, 32'h0000_0000, 1'b0},
    '{bspu_pkg::OP_NONE,   32'hFFFF_FFFF, 6'd32, 1'b1, 32'h0000_0000, 1'b0},
    '{bspu_pkg::OP_WRITE,  32'h8000_0001, 6'd63, 1'b0, 32'h0,         1'b0},
    '{bspu_pkg::OP_WRITE,  32'hC3A5_5A3C, 6'd32, 1'b0, 32'h0,         1'b0},
    '{bspu_pkg::OP_REWIND, 32'h0000_0000, 6'd0,  1'b1, 32'h0000_0000, 1'b0},
    '{bspu_pkg::OP_READ,   32'h0000_0000, 6'd33, 1'b0, 32'h0,         1'b0},
    '{bspu_pkg::OP_READ,   32'h0000_0000, 6'd4,  1'b0, 32'h0,         1'b0},
    '{bspu_pkg::OP_READ,   32'h0000_0000, 6'd63, 1'b0, 32'h0,         1'b0},
    '{bspu_pkg::OP_READ,   32'h0000_0000, 6'd32, 1'b0, 32'h0,         1'b0},
    '{bspu_pkg::OP_NONE,   32'h0000_0000, 6'd0,  1'b1, 32'h0000_0000, 1'b0},
    '{bspu_pkg::OP_READ,   32'h0000_0000, 6'd7,  1'b0, 32'h0,         1'b0},
    '{bspu_pkg::OP_REWIND, 32'h0000_0000, 6'd0,  1'b1, 32'h0000_0000, 1'b0}
  };

  // Apply one item to the shadow and return what the block should answer.
  function automatic outcome_t stream_access(input bspu_pkg::op_e op,
                                             input logic [bspu_pkg::DATA_W-1:0] value,
                                             input logic [bspu_pkg::LEN_W-1:0] bits);
    outcome_t    res;
    int unsigned n;
    int unsigned pos;
    int unsigned p;
    int unsigned i;
    res = '0;
    n   = (bits > WIDEST_FIELD) ? WIDEST_FIELD : bits;
    pos = shadow_cursor;
    if (op == bspu_pkg::OP_REWIND) begin
      shadow_cursor = 0;
    end else if ((op == bspu_pkg::OP_WRITE || op == bspu_pkg::OP_READ) && n != 0) begin
      if (pos + n > STORE_BITS) begin
        // Refuse: store and cursor stay as they are.
        res.overflow = 1'b1;
        refusals_seen++;
      end else begin
        for (i = 0; i < n; i++) begin
          p = pos + i;
          if (op == bspu_pkg::OP_WRITE) begin
            if (value[n-1-i])
              shadow_store[p/bspu_pkg::BYTE_W][7-(p%bspu_pkg::BYTE_W)] = 1'b1;
          end else begin
            res.read_value[n-1-i] =
              shadow_store[p/bspu_pkg::BYTE_W][7-(p%bspu_pkg::BYTE_W)];
          end
        end
        shadow_cursor = pos + n;
        if (op == bspu_pkg::OP_WRITE) writes_done++;
        else reads_done++;
      end
    end
    return res;
  endfunction

  // Mostly sparse values so that stored bytes do not fill with ones too soon.
  function automatic logic [bspu_pkg::DATA_W-1:0] pick_value();
    logic [bspu_pkg::DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2, 3, 4: v = $urandom;
      default: v = $urandom & $urandom & $urandom & $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [bspu_pkg::LEN_W-1:0] pick_width();
    int unsigned r;
    logic [bspu_pkg::LEN_W-1:0] w;
    r = $urandom_range(0, 99);
    if (r < 3)       w = '0;
    else if (r < 10) w = bspu_pkg::LEN_W'($urandom_range(33, 63));
    else if (r < 22) w = bspu_pkg::LEN_W'(WIDEST_FIELD);
    else             w = bspu_pkg::LEN_W'($urandom_range(1, 31));
    return w;
  endfunction

  // Hand one item to the block; the sender idles between bursts unless it
  // is in a steady stretch.
  task automatic push_item(input bspu_pkg::op_e op,
                           input logic [bspu_pkg::DATA_W-1:0] value,
                           input logic [bspu_pkg::LEN_W-1:0] bits, input logic use_typed,
                           input outcome_t typed_out);
    outcome_t    predicted;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = sender_steady ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        items_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    predicted = stream_access(op, value, bits);
    outcomes_due.push_back(use_typed ? typed_out : predicted);
    items_ch.valid       <= 1'b1;
    items_ch.operation   <= op;
    items_ch.write_value <= value;
    items_ch.field_bits  <= bits;
    do @(posedge clk_i); while (!items_ch.ready);
    burst_left--;
    items_sent++;
    if (op != bspu_pkg::OP_NONE &&
        !((op == bspu_pkg::OP_WRITE || op == bspu_pkg::OP_READ) && bits == 0))
      items_counted++;
  endtask

  task automatic push_access(input bspu_pkg::op_e op,
                             input logic [bspu_pkg::DATA_W-1:0] value,
                             input logic [bspu_pkg::LEN_W-1:0] bits);
    push_item(op, value, bits, 1'b0, '0);
  endtask

  // Hold the sender until every owed result has come back.
  task automatic drain_results();
    items_ch.valid <= 1'b0;
    burst_left = 0;
    while (outcomes_due.size() != 0) @(posedge clk_i);
  endtask

  // Optionally rewind, then walk accesses until the cursor sits exactly on the end of the
  // store (refusals along the way), then try once more past the end.
  task automatic fill_to_end();
    bspu_pkg::op_e op;
    if ($urandom_range(0, 3) != 0)
      push_access(bspu_pkg::OP_REWIND, pick_value(), pick_width());
    while (shadow_cursor < STORE_BITS) begin
      op = $urandom_range(0, 1) ? bspu_pkg::OP_WRITE : bspu_pkg::OP_READ;
      push_access(op, pick_value(), pick_width());
    end
    op = $urandom_range(0, 1) ? bspu_pkg::OP_WRITE : bspu_pkg::OP_READ;
    push_access(op, pick_value(), bspu_pkg::LEN_W'($urandom_range(1, 63)));
  endtask

  task automatic run_segment();
    int unsigned   kind;
    int unsigned   count;
    int unsigned   k;
    bspu_pkg::op_e op;
    kind          = $urandom_range(0, 99);
    sender_steady = ($urandom_range(0, 3) == 0);
    if (kind < 12) begin
      // Noise: any code, any width, including unused and zero-width items.
      count = $urandom_range(4, 20);
      for (k = 0; k < count; k++)
        push_access(bspu_pkg::op_e'($urandom_range(0, 3)), $urandom,
                    bspu_pkg::LEN_W'($urandom_range(0, 63)));
    end else if (kind < 22) begin
      fill_to_end();
    end else begin
      // Well-formed stream: usually from the start, a run of one kind of
      // access or a mix, long enough to reach the end now and then.
      if ($urandom_range(0, 4) != 0) push_access(bspu_pkg::OP_REWIND, '0, '0);
      count = $urandom_range(8, 90);
      for (k = 0; k < count; k++) begin
        if (kind < 50)      op = bspu_pkg::OP_WRITE;
        else if (kind < 82) op = bspu_pkg::OP_READ;
        else                op = $urandom_range(0, 1) ? bspu_pkg::OP_WRITE
                                                      : bspu_pkg::OP_READ;
        push_access(op, pick_value(), pick_width());
      end
    end
    if ($urandom_range(0, 11) == 0) drain_results();
  endtask

  // 2 ns clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: check each transfer on the result channel, then pick the next
  // ready level from the current stall mode.
  initial begin
    outcome_t    due;
    int unsigned mode;
    int unsigned mode_left;
    int unsigned stall_left;
    mode       = 0;
    mode_left  = 0;
    stall_left = 0;
    results_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && results_ch.valid && results_ch.ready) begin
        results_seen++;
        if (outcomes_due.size() == 0) begin
          $error("result with nothing owed: read_value %h overflow %b",
                 results_ch.read_value, results_ch.overflow);
          error_count++;
        end else begin
          due = outcomes_due.pop_front();
          if (results_ch.read_value !== due.read_value) begin
            $error("read_value mismatch: expected %h, got %h",
                   due.read_value, results_ch.read_value);
            error_count++;
          end
          if (results_ch.overflow !== due.overflow) begin
            $error("overflow mismatch: expected %b, got %b",
                   due.overflow, results_ch.overflow);
            error_count++;
          end
        end
      end
      // Switch mode now and then: always ready, coin toss, or rare long stalls.
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      if (stall_left != 0) begin
        results_ch.ready <= 1'b0;
        stall_left--;
      end else if (mode == 0) begin
        results_ch.ready <= 1'b1;
      end else if (mode == 1) begin
        results_ch.ready <= 1'($urandom_range(0, 1));
      end else if ($urandom_range(0, 9) == 0) begin
        results_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 7);
      end else begin
        results_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either channel for too
  // long. The limit covers the clearing pass after reset with a wide margin.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results still owed",
                 idle_cycles, outcomes_due.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, random streams, drain and report.
  initial begin
    int unsigned row;
    int unsigned directed_counted;
    outcome_t    typed_out;
    error_count   = 0;
    items_sent    = 0;
    items_counted = 0;
    results_seen  = 0;
    reads_done    = 0;
    writes_done   = 0;
    refusals_seen = 0;
    burst_left    = 0;
    sender_steady = 1'b0;
    shadow_cursor = 0;
    foreach (shadow_store[b]) shadow_store[b] = '0;
    items_ch.valid       = 1'b0;
    items_ch.operation   = bspu_pkg::OP_NONE;
    items_ch.write_value = '0;
    items_ch.field_bits  = '0;
    rst_ni = 1'b0;

    // Hold reset, then release it; the block then clears its store on its own.
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: typed outcomes where given, the shadow's otherwise.
    for (row = 0; row < N_DIRECTED; row++) begin
      typed_out.read_value = directed_table[row].typed_value;
      typed_out.overflow   = directed_table[row].typed_overflow;
      push_item(directed_table[row].op, directed_table[row].value,
                directed_table[row].bits, directed_table[row].has_typed, typed_out);
    end
    drain_results();
    directed_counted = items_counted;

    // Random part: open with a walk to the exact end and past it, then mixed
    // segments until enough items have gone in.
    fill_to_end();
    while (items_counted < directed_counted + RANDOM_ITEMS) run_segment();

    // Drop valid, wait for every owed result, then let stray ones show up.
    items_ch.valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d items: %0d writes and %0d reads carried out, %0d refused",
             items_sent, writes_done, reads_done, refusals_seen);
    $display("%0d results compared, %0d mismatches or strays", results_seen, error_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* bit_stream_packer_unpacker_top.f */
+incdir+hdl
hdl/bspu_pkg.sv
hdl/bspu_if.sv
hdl/bspu_ram.sv
hdl/bspu_seq.sv
hdl/bit_stream_packer_unpacker_top.sv
tb/tb_bit_stream_packer_unpacker_top.sv
